/* hdl/kot_pkg.sv */
// Shared types, token kind codes and character classification for the tokenizer.
`default_nettype none

package kot_pkg;

  localparam int unsigned PositionBitsDef = 16;
  localparam int unsigned FifoDepth       = 4;
  localparam int unsigned WindowBytes     = 6;

  localparam logic [15:0] LenMax = 16'hFFFF;

  typedef logic [4:0] kind_t;

  localparam kind_t KindIllegal  = 5'd0;
  localparam kind_t KindEof      = 5'd1;
  localparam kind_t KindIdent    = 5'd2;
  localparam kind_t KindDefn     = 5'd3;
  localparam kind_t KindLet      = 5'd4;
  localparam kind_t KindTrue     = 5'd5;
  localparam kind_t KindFalse    = 5'd6;
  localparam kind_t KindIf       = 5'd7;
  localparam kind_t KindElse     = 5'd8;
  localparam kind_t KindWhile    = 5'd9;
  localparam kind_t KindReturn   = 5'd10;
  localparam kind_t KindAssign   = 5'd11;
  localparam kind_t KindEqual    = 5'd12;
  localparam kind_t KindPlus     = 5'd13;
  localparam kind_t KindMinus    = 5'd14;
  localparam kind_t KindBang     = 5'd15;
  localparam kind_t KindNotEqual = 5'd16;
  localparam kind_t KindStar     = 5'd17;
  localparam kind_t KindSlash    = 5'd18;
  localparam kind_t KindLess     = 5'd19;
  localparam kind_t KindGreater  = 5'd20;
  localparam kind_t KindComma    = 5'd21;
  localparam kind_t KindSemi     = 5'd22;
  localparam kind_t KindLParen   = 5'd23;
  localparam kind_t KindRParen   = 5'd24;
  localparam kind_t KindLBrace   = 5'd25;
  localparam kind_t KindRBrace   = 5'd26;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChUnder = 8'h5F;

  typedef enum logic [1:0] {
    HoldNone   = 2'd0,
    HoldAssign = 2'd1,
    HoldBang   = 2'd2
  } hold_e;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  // Tokens produced by one byte, at most two.
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == ChUnder);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic kind_t single_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2B:   k = KindPlus;
      8'h2D:   k = KindMinus;
      8'h2A:   k = KindStar;
      8'h2F:   k = KindSlash;
      8'h3C:   k = KindLess;
      8'h3E:   k = KindGreater;
      8'h2C:   k = KindComma;
      8'h3B:   k = KindSemi;
      8'h28:   k = KindLParen;
      8'h29:   k = KindRParen;
      8'h7B:   k = KindLBrace;
      8'h7D:   k = KindRBrace;
      default: k = KindIllegal;
    endcase
    return k;
  endfunction

  // Keyword text packed first byte in the low bits, zero above the length.
  function automatic kind_t keyword_kind(input logic [15:0] len, input logic [47:0] win);
    kind_t k;
    k = KindIdent;
    if      (len == 16'd4 && win == 48'h00006E666564) k = KindDefn;
    else if (len == 16'd3 && win == 48'h00000074656C) k = KindLet;
    else if (len == 16'd4 && win == 48'h000065757274) k = KindTrue;
    else if (len == 16'd5 && win == 48'h0065736C6166) k = KindFalse;
    else if (len == 16'd2 && win == 48'h000000006669) k = KindIf;
    else if (len == 16'd4 && win == 48'h000065736C65) k = KindElse;
    else if (len == 16'd5 && win == 48'h00656C696877) k = KindWhile;
    else if (len == 16'd6 && win == 48'h6E7275746572) k = KindReturn;
    return k;
  endfunction

endpackage

`default_nettype wire

/* hdl/kot_lexer.sv */
// Input byte register and scanner state; turns one byte into zero to two tokens.
`default_nettype none

module kot_lexer #(
  parameter int unsigned POSITION_BITS = kot_pkg::PositionBitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    char_in_i,
  input  wire logic          char_in_valid_i,
  output logic               char_in_ready_o,
  input  wire logic          room_i,
  output kot_pkg::push_t     push_o
);
  import kot_pkg::*;

  logic                     in_vld_q, in_vld_d;
  logic [7:0]               in_byte_q;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  hold_e                    hold_q, hold_d;
  logic                     in_id_q, in_id_d;
  logic [15:0]              id_start_q, id_start_d;
  logic [15:0]              id_len_q, id_len_d;
  logic [47:0]              win_q, win_d;

  logic                     proc;
  logic                     acc;
  logic [POSITION_BITS-1:0] prev;
  logic                     a_v, b_v, consumed;
  token_t                   tok_a, tok_b;
  logic [7:0]               c;

  assign proc            = in_vld_q && room_i;
  assign char_in_ready_o = !in_vld_q || proc;
  assign acc             = char_in_valid_i && char_in_ready_o;
  assign c               = in_byte_q;
  assign prev            = pos_q - POSITION_BITS'(1);

  always_comb begin
    in_vld_d = in_vld_q;
    if (acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    hold_d     = hold_q;
    in_id_d    = in_id_q;
    id_start_d = id_start_q;
    id_len_d   = id_len_q;
    win_d      = win_q;
    pos_d      = pos_q + POSITION_BITS'(1);
    a_v        = 1'b0;
    b_v        = 1'b0;
    consumed   = 1'b0;
    tok_a      = '0;
    tok_b      = '0;

    // release a held operator, or extend/close an open identifier
    if (hold_q != HoldNone) begin
      a_v         = 1'b1;
      tok_a.start = 16'(prev);
      if (c == ChEq) begin
        tok_a.kind   = (hold_q == HoldBang) ? KindNotEqual : KindEqual;
        tok_a.length = 16'd2;
        consumed     = 1'b1;
      end else begin
        tok_a.kind   = (hold_q == HoldBang) ? KindBang : KindAssign;
        tok_a.length = 16'd1;
      end
      hold_d = HoldNone;
    end else if (in_id_q) begin
      if (is_letter(c) || is_digit(c)) begin
        for (int i = 0; i < WindowBytes; i++) begin
          if (id_len_q == 16'(i)) begin
            win_d[8*i +: 8] = c;
          end
        end
        if (id_len_q != LenMax) begin
          id_len_d = id_len_q + 16'd1;
        end
        consumed = 1'b1;
      end else begin
        a_v          = 1'b1;
        tok_a.kind   = keyword_kind(id_len_q, win_q);
        tok_a.start  = id_start_q;
        tok_a.length = id_len_q;
        in_id_d      = 1'b0;
        id_len_d     = '0;
        win_d        = '0;
      end
    end

    // the byte itself, when not absorbed above
    if (!consumed) begin
      if (c == ChNul) begin
        b_v          = 1'b1;
        tok_b.kind   = KindEof;
        tok_b.start  = 16'(pos_q);
        tok_b.length = '0;
        pos_d        = '0;
        hold_d       = HoldNone;
        in_id_d      = 1'b0;
        id_start_d   = '0;
        id_len_d     = '0;
        win_d        = '0;
      end else if (c == ChSpace || c == ChTab) begin
        // skipped
      end else if (c == ChEq) begin
        hold_d = HoldAssign;
      end else if (c == ChBang) begin
        hold_d = HoldBang;
      end else if (is_letter(c)) begin
        in_id_d    = 1'b1;
        id_start_d = 16'(pos_q);
        id_len_d   = 16'd1;
        win_d      = 48'(c);
      end else begin
        b_v          = 1'b1;
        tok_b.kind   = single_kind(c);
        tok_b.start  = 16'(pos_q);
        tok_b.length = 16'd1;
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (proc) begin
      if (a_v && b_v) begin
        push_o.cnt       = 2'd2;
        push_o.tok0      = tok_a;
        push_o.tok1      = tok_b;
        push_o.tok1.last = 1'b1;
      end else if (a_v) begin
        push_o.cnt       = 2'd1;
        push_o.tok0      = tok_a;
        push_o.tok0.last = 1'b1;
      end else if (b_v) begin
        push_o.cnt       = 2'd1;
        push_o.tok0      = tok_b;
        push_o.tok0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      pos_q      <= '0;
      hold_q     <= HoldNone;
      in_id_q    <= 1'b0;
      id_start_q <= '0;
      id_len_q   <= '0;
      win_q      <= '0;
    end else begin
      in_vld_q <= in_vld_d;
      if (proc) begin
        pos_q      <= pos_d;
        hold_q     <= hold_d;
        in_id_q    <= in_id_d;
        id_start_q <= id_start_d;
        id_len_q   <= id_len_d;
        win_q      <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_byte_q <= char_in_i;
    end
  end

`ifndef SYNTHESIS
  a_hold_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != HoldNone) |-> !in_id_q)
    else $error("held operator while identifier open");
  a_id_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_id_q |-> (id_len_q != 16'd0))
    else $error("open identifier with zero length");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.cnt != 2'd0) |-> (proc && push_o.cnt != 2'd3))
    else $error("tokens pushed without a byte step");
`endif

endmodule

`default_nettype wire

/* hdl/kot_fifo.sv */
// Token queue taking up to two tokens per cycle and giving one per transfer.
`default_nettype none

module kot_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  kot_pkg::push_t     push_i,
  output logic               room_o,
  output kot_pkg::token_t    tok_o,
  output logic               valid_o,
  input  wire logic          ready_i
);
  import kot_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  token_t          mem [FifoDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem[rp_q];
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));

  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.cnt);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wp_q] <= push_i.tok0;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wp_q + PtrW'(1)] <= push_i.tok1;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.cnt != 2'd0) |-> room_o)
    else $error("push into a full token queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("token queue count out of range");
  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PtrW'(wp_q - rp_q) == PtrW'(cnt_q)))
    else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

/* hdl/keyword_operator_tokenizer.sv */
// Top level of the byte-serial keyword and operator tokenizer.
// Usage:
//  - Input channel char_in: one source byte per transfer (valid/ready).
//    Byte 0 ends the string: pending tokens are flushed, Eof is sent and
//    all scanner state returns to reset for the next string.
//  - Output channel token: one token per transfer, with kind, start
//    position (low 16 bits), length (saturating) and last_of_run, which
//    marks the final token caused by one input byte.
//  - Throughput: one byte per cycle while two queue entries are free. The
//    scanner step is combinational logic between the input byte register
//    and a four-entry token queue. Each byte passes through the input
//    register, then its tokens are written into the queue and sent out.
//  - A byte that closes an identifier or releases a held '=' / '!' may
//    give two tokens; the queue takes both in the same cycle.
//  - Stall: when the receiver holds ready low the queue fills; the input
//    register then holds its byte and char_in_ready_o drops once fewer
//    than two queue entries are free. Nothing is lost or repeated.
//  - Reset (rst_ni low, asynchronous): queue empty, position zero, no
//    identifier or operator pending, input register empty.
`default_nettype none

module keyword_operator_tokenizer #(
  parameter int unsigned POSITION_BITS = kot_pkg::PositionBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  char_in_i,
  input  wire logic        char_in_valid_i,
  output logic             char_in_ready_o,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o,
  output logic             token_valid_o,
  input  wire logic        token_ready_i
);
  import kot_pkg::*;

  push_t  push;
  logic   room;
  token_t tok;

  // scanner: input byte register, position and identifier state
  kot_lexer #(
    .POSITION_BITS(POSITION_BITS)
  ) u_lexer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .char_in_i      (char_in_i),
    .char_in_valid_i(char_in_valid_i),
    .char_in_ready_o(char_in_ready_o),
    .room_i         (room),
    .push_o         (push)
  );

  // result queue decouples the two-token bursts from the receiver
  kot_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .tok_o  (tok),
    .valid_o(token_valid_o),
    .ready_i(token_ready_i)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.length;
  assign last_of_run_o  = tok.last;

endmodule

`default_nettype wire
